### rtl/core/idq_pkg.sv
`timescale 1ns / 1ps

package idq_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CONTAINS   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]   popped_value;
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    entry_count;
  } result_t;

  // Ring position base + off, wrapped into the store; both inputs are below DEPTH.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W + 1)'(DEPTH)) begin
      sum = sum - (IDX_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### rtl/core/idq_ram.sv
`timescale 1ns / 1ps

module idq_ram #(
  parameter int DATA_W    = 32,
  parameter int NUM_WORDS = 64,
  parameter int ADDR_W    = $clog2(NUM_WORDS)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/idq_ctrl.sv
`timescale 1ns / 1ps

module idq_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [idq_pkg::KIND_W-1:0]        kind,
  input  logic signed [idq_pkg::DATA_W-1:0] operand_value,
  input  logic                              slot_free,
  output idq_pkg::mem_req_t                 mem_req,
  input  logic [idq_pkg::DATA_W-1:0]        rdata,
  output logic                              res_valid,
  output idq_pkg::result_t                  res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]                       state, state_next;
  logic [idq_pkg::IDX_W-1:0]        front, front_next;
  logic [idq_pkg::CNT_W-1:0]        count, count_next;
  logic [idq_pkg::IDX_W-1:0]        scan_idx, scan_idx_next;
  logic [idq_pkg::DATA_W-1:0]       scan_val, scan_val_next;

  logic                             accept;
  logic                             full;
  logic                             empty;
  logic [idq_pkg::IDX_W-1:0]        count_low;
  logic [idq_pkg::IDX_W-1:0]        last_off;
  logic [idq_pkg::IDX_W-1:0]        front_dec;

  assign in_stall  = (state != S_IDLE) || !slot_free;
  assign accept    = in_valid && !in_stall;
  assign full      = (count == idq_pkg::CNT_W'(idq_pkg::DEPTH));
  assign empty     = (count == '0);
  assign count_low = count[idq_pkg::IDX_W-1:0];
  assign last_off  = idq_pkg::IDX_W'(count - idq_pkg::CNT_W'(1));
  assign front_dec = (front == '0) ? idq_pkg::IDX_W'(idq_pkg::DEPTH - 1)
                                   : front - idq_pkg::IDX_W'(1);

  always_comb begin
    state_next    = state;
    front_next    = front;
    count_next    = count;
    scan_idx_next = scan_idx;
    scan_val_next = scan_val;
    mem_req       = '0;
    mem_req.raddr = front;
    res_valid     = 1'b0;
    res           = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (kind)
            idq_pkg::KIND_PUSH_FRONT: begin
              res_valid = 1'b1;
              if (full) begin
                res.status = idq_pkg::ST_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = front_dec;
                mem_req.wdata = operand_value;
                front_next    = front_dec;
                count_next    = count + idq_pkg::CNT_W'(1);
              end
            end
            idq_pkg::KIND_PUSH_BACK: begin
              res_valid = 1'b1;
              if (full) begin
                res.status = idq_pkg::ST_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idq_pkg::ring_add(front, count_low);
                mem_req.wdata = operand_value;
                count_next    = count + idq_pkg::CNT_W'(1);
              end
            end
            idq_pkg::KIND_POP_FRONT: begin
              if (empty) begin
                res_valid  = 1'b1;
                res.status = idq_pkg::ST_EMPTY;
              end else begin
                mem_req.raddr = front;
                front_next    = idq_pkg::ring_add(front, idq_pkg::IDX_W'(1));
                count_next    = count - idq_pkg::CNT_W'(1);
                state_next    = S_POP;
              end
            end
            idq_pkg::KIND_POP_BACK: begin
              if (empty) begin
                res_valid  = 1'b1;
                res.status = idq_pkg::ST_EMPTY;
              end else begin
                mem_req.raddr = idq_pkg::ring_add(front, last_off);
                count_next    = count - idq_pkg::CNT_W'(1);
                state_next    = S_POP;
              end
            end
            idq_pkg::KIND_CONTAINS: begin
              if (empty) begin
                res_valid = 1'b1;
              end else begin
                mem_req.raddr = front;
                scan_idx_next = '0;
                scan_val_next = operand_value;
                state_next    = S_SCAN;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        res_valid        = 1'b1;
        res.popped_value = rdata;
        state_next       = S_IDLE;
      end
      S_SCAN: begin
        // The word arriving now belongs to scan_idx; the next one is requested alongside.
        if (rdata == scan_val) begin
          res_valid  = 1'b1;
          res.found  = 1'b1;
          state_next = S_IDLE;
        end else if (scan_idx == last_off) begin
          res_valid  = 1'b1;
          state_next = S_IDLE;
        end else begin
          scan_idx_next = scan_idx + idq_pkg::IDX_W'(1);
          mem_req.raddr = idq_pkg::ring_add(front, scan_idx + idq_pkg::IDX_W'(1));
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res.entry_count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    scan_val <= scan_val_next;
  end

endmodule

### rtl/core/integer_deque_with_search_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Word
// input     in         in_valid / in_stall  kind, operand_value
// output    out        out_valid / out_stall popped_value, found, status, entry_count
//
// A push, a pop from an empty store, a search of an empty store or a request of unknown
// kind is answered at once from the controller; any other pop waits for the registered
// read of the entry store. A search of a non-empty store reads one entry per cycle
// through the single read port of the store, until a match or the last entry.
// Reset clears the front index, the entry count and the controller; the store itself
// is not cleared, as only entries written by a push are ever read.
// A held output word stalls the input side through the single output register.

module integer_deque_with_search_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [idq_pkg::KIND_W-1:0]          kind,
  input  logic signed [idq_pkg::DATA_W-1:0]   operand_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [idq_pkg::DATA_W-1:0]   popped_value,
  output logic                                found,
  output logic [idq_pkg::STATUS_W-1:0]        status,
  output logic [idq_pkg::CNT_W-1:0]           entry_count
);

  idq_pkg::mem_req_t          mem_req;
  idq_pkg::result_t           res;
  idq_pkg::result_t           out_word;
  logic                       res_valid;
  logic                       slot_free;
  logic [idq_pkg::DATA_W-1:0] rdata;

  assign slot_free = !out_valid || !out_stall;

  idq_ram #(
    .DATA_W    (idq_pkg::DATA_W),
    .NUM_WORDS (idq_pkg::DEPTH),
    .ADDR_W    (idq_pkg::IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  idq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .operand_value (operand_value),
    .slot_free     (slot_free),
    .mem_req       (mem_req),
    .rdata         (rdata),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_word <= res;
    end
  end

  assign popped_value = out_word.popped_value;
  assign found        = out_word.found;
  assign status       = out_word.status;
  assign entry_count  = out_word.entry_count;

  // A result must never overwrite a word that is still held by the output side.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> slot_free)
    else $error("result produced while the output word is held");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count <= idq_pkg::CNT_W'(idq_pkg::DEPTH)))
    else $error("entry count beyond the store depth");

  a_error_clean : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != idq_pkg::ST_OK)) |-> ((popped_value == '0) && !found))
    else $error("error word carries a value or a match");

  // A word that is not answered at once keeps the input side stalled while it is worked on.
  a_accept_result : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !res_valid) |=> in_stall)
    else $error("accepted word neither answered nor held in progress");

endmodule
